// File: sv/rotate_point_about_center_core_assert.svh
// Assertion macros for the point rotation core
`ifndef ROTATE_POINT_ABOUT_CENTER_CORE_ASSERT_SVH
`define ROTATE_POINT_ABOUT_CENTER_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RPC_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("lbl failed");
// next-cycle implication
`define RPC_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("lbl failed");
`endif

// File: sv/rpc_pkg.sv
// Types, constants and helpers shared by the point rotation core
package rpc_pkg;
    localparam int CORDIC_STEPS = 18;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] z;
        logic               neg;
    } cordic_t;

    typedef struct packed {
        cordic_t            yaw;
        cordic_t            pitch;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } cell_data_t;

    function automatic logic signed [33:0] atan_turns(input int i);
        case (i)
            0:  atan_turns = 34'sd536870912;
            1:  atan_turns = 34'sd316933406;
            2:  atan_turns = 34'sd167458907;
            3:  atan_turns = 34'sd85004757;
            4:  atan_turns = 34'sd42667331;
            5:  atan_turns = 34'sd21354465;
            6:  atan_turns = 34'sd10679838;
            7:  atan_turns = 34'sd5340245;
            8:  atan_turns = 34'sd2670163;
            9:  atan_turns = 34'sd1335087;
            10: atan_turns = 34'sd667544;
            11: atan_turns = 34'sd333772;
            12: atan_turns = 34'sd166886;
            13: atan_turns = 34'sd83443;
            14: atan_turns = 34'sd41722;
            15: atan_turns = 34'sd20861;
            16: atan_turns = 34'sd10430;
            17: atan_turns = 34'sd5215;
            default: atan_turns = 34'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       sat32 = 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = v[31:0];
    endfunction

    // initial CORDIC vector with quadrant folding
    function automatic cordic_t cordic_init(input logic [15:0] a);
        cordic_t r;
        logic signed [33:0] z;
        z = 34'(signed'({a, 16'h0000}));
        r.neg = 1'b0;
        if (z > 34'sd1073741824) begin
            z = z - 34'sd2147483648;
            r.neg = 1'b1;
        end else if (z < -34'sd1073741824) begin
            z = z + 34'sd2147483648;
            r.neg = 1'b1;
        end
        r.x = CORDIC_GAIN_Q30;
        r.y = '0;
        r.z = z;
        return r;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t c, input int i);
        cordic_t r;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        xs = c.x >>> i;
        ys = c.y >>> i;
        r = c;
        if (c.z >= 0) begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - atan_turns(i);
        end else begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + atan_turns(i);
        end
        return r;
    endfunction
endpackage

// File: sv/rpc_cordic_cell.sv
// One CORDIC micro-rotation cell for both angles, with pipeline valid
module rpc_cordic_cell import rpc_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  cell_data_t in_data,
    output logic       out_valid,
    output cell_data_t out_data
);
    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb begin
        data_next = in_data;
        data_next.yaw = cordic_step(in_data.yaw, STEP);
        data_next.pitch = cordic_step(in_data.pitch, STEP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;
endmodule

// File: sv/rpc_rotate_back.sv
// Two rotation stages after the CORDIC row: yaw, then pitch and pivot restore
module rpc_rotate_back import rpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  cell_data_t         in_data,
    output logic               out_valid,
    output logic signed [31:0] rx,
    output logic signed [31:0] ry,
    output logic signed [31:0] rz
);
    logic signed [31:0] s1, c1, s2, c2;
    logic signed [65:0] p0, p1, p2, p3;
    logic signed [31:0] nx_reg, nz_reg, ny_reg, cx_reg, cy_reg, cz_reg;
    logic signed [31:0] s2_reg, c2_reg;
    logic signed [31:0] nx_next, nz_next;
    logic signed [63:0] sx, sz, sy2, sz2;
    logic signed [65:0] q0, q1, q2, q3;
    logic signed [31:0] my, mz;
    logic               v1_reg, v2_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;

    always_comb begin
        s1 = in_data.yaw.neg ? -in_data.yaw.y : in_data.yaw.y;
        c1 = in_data.yaw.neg ? -in_data.yaw.x : in_data.yaw.x;
        s2 = in_data.pitch.neg ? -in_data.pitch.y : in_data.pitch.y;
        c2 = in_data.pitch.neg ? -in_data.pitch.x : in_data.pitch.x;
        sx = 64'(in_data.dx) * 64'(c1);
        sz = 64'(in_data.dz) * 64'(s1);
        p0 = 66'(sx) + 66'(sz) + 66'sd536870912;
        p1 = 66'(in_data.dz) * 66'(c1) - 66'(in_data.dx) * 66'(s1) + 66'sd536870912;
        nx_next = sat32(p0 >>> 30);
        nz_next = sat32(p1 >>> 30);
        sy2 = 64'(ny_reg) * 64'(c2_reg);
        sz2 = 64'(nz_reg) * 64'(s2_reg);
        q0 = 66'(sy2) - 66'(sz2) + 66'sd536870912;
        q1 = 66'(ny_reg) * 66'(s2_reg) + 66'(nz_reg) * 66'(c2_reg) + 66'sd536870912;
        my = sat32(q0 >>> 30);
        mz = sat32(q1 >>> 30);
        q2 = 66'(my) + 66'(cy_reg);
        q3 = 66'(mz) + 66'(cz_reg);
        p2 = 66'(nx_reg) + 66'(cx_reg);
        p3 = q2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            nx_reg <= nx_next;
            nz_reg <= nz_next;
            ny_reg <= in_data.dy;
            s2_reg <= s2;
            c2_reg <= c2;
            cx_reg <= in_data.cx;
            cy_reg <= in_data.cy;
            cz_reg <= in_data.cz;
            rx_reg <= sat32(p2);
            ry_reg <= sat32(p3);
            rz_reg <= sat32(q3);
        end
    end

    assign out_valid = v2_reg;
    assign rx = rx_reg;
    assign ry = ry_reg;
    assign rz = rz_reg;
endmodule

// File: sv/rotate_point_about_center_core.sv
// Point rotation about a pivot: a row of CORDIC cells then two rotation stages
// Registers from input accept to result valid: entry, 18 cells, 2 rotation stages (21 in all).
// Throughput: one item per cycle; the whole pipe advances together with one
// stall enable, an item enters every cycle while the output register is empty or being taken.
// Reset: synchronous active-low aresetn clears every stage valid bit.
module rotate_point_about_center_core import rpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic        [15:0] s_yaw_angle,
    input  logic        [15:0] s_pitch_angle,
    input  logic signed [31:0] s_pivot_x,
    input  logic signed [31:0] s_pivot_y,
    input  logic signed [31:0] s_pivot_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_rotated_x,
    output logic signed [31:0] m_rotated_y,
    output logic signed [31:0] m_rotated_z
);
`include "rotate_point_about_center_core_assert.svh"

    logic       en;
    logic       v0_reg;
    cell_data_t d0_reg;
    cell_data_t d0_next;
    logic       cv [CORDIC_STEPS+1];
    cell_data_t cd [CORDIC_STEPS+1];

    // pipeline moves whenever the output register is empty or being taken
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        d0_next.yaw = cordic_init(s_yaw_angle);
        d0_next.pitch = cordic_init(s_pitch_angle);
        d0_next.dx = sat32(66'(s_point_x) - 66'(s_pivot_x));
        d0_next.dy = sat32(66'(s_point_y) - 66'(s_pivot_y));
        d0_next.dz = sat32(66'(s_point_z) - 66'(s_pivot_z));
        d0_next.cx = s_pivot_x;
        d0_next.cy = s_pivot_y;
        d0_next.cz = s_pivot_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
        if (en) begin
            d0_reg <= d0_next;
        end
    end

    assign cv[0] = v0_reg;
    assign cd[0] = d0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        rpc_cordic_cell #(.STEP(i)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(cv[i]), .in_data(cd[i]),
            .out_valid(cv[i+1]), .out_data(cd[i+1])
        );
    end

    rpc_rotate_back u_back (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(cv[CORDIC_STEPS]), .in_data(cd[CORDIC_STEPS]),
        .out_valid(m_valid),
        .rx(m_rotated_x), .ry(m_rotated_y), .rz(m_rotated_z)
    );

    `RPC_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_rotated_x))
    `RPC_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `RPC_ASSERT_NEXT(a_entry_valid, aclk, aresetn, s_valid && s_ready, v0_reg)
endmodule

// File: sim/rotate_point_about_center_core_tb.sv
// Testbench for the point rotation core: queued stimulus, CORDIC predictor, result check
module rotate_point_about_center_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic        [15:0] yaw, pitch;
        logic signed [31:0] cx, cy, cz;
    } point_item_t;

    typedef struct {
        logic signed [31:0] x, y, z;
    } rotated_t;

    localparam int PIPE_LATENCY = 21;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_point_x = '0;
    logic signed [31:0] s_point_y = '0;
    logic signed [31:0] s_point_z = '0;
    logic        [15:0] s_yaw_angle = '0;
    logic        [15:0] s_pitch_angle = '0;
    logic signed [31:0] s_pivot_x = '0;
    logic signed [31:0] s_pivot_y = '0;
    logic signed [31:0] s_pivot_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_rotated_x;
    logic signed [31:0] m_rotated_y;
    logic signed [31:0] m_rotated_z;

    point_item_t pending_points[$];
    rotated_t    expected_points[$];
    int          mismatches = 0;
    bit          stimulus_done = 1'b0;

    rotate_point_about_center_core dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_step(input int i);
        longint tbl[18] = '{536870912, 316933406, 167458907, 85004757, 42667331,
                            21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                            333772, 166886, 83443, 41722, 20861, 10430, 5215};
        return tbl[i];
    endfunction

    // sine and cosine in Q2.30 from a binary angle
    function automatic void cordic_sincos(input logic [15:0] ang, output longint sn,
                                          output longint cs);
        longint z, x, y, xs, ys;
        bit     flip;
        z = longint'(signed'({ang, 16'h0000}));
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < 18; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= atan_step(i);
            end else begin
                x += ys;
                y -= xs;
                z += atan_step(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic longint mac_q30(input longint a, p, b, q);
        return clamp32((a * p + b * q + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function automatic rotated_t rotate_about_pivot(input point_item_t it);
        longint dx, dy, dz, cx, cy, cz, s1, c1, s2, c2, nx, nz, my, mz;
        rotated_t r;
        cx = it.cx;
        cy = it.cy;
        cz = it.cz;
        dx = clamp32(longint'(it.px) - cx);
        dy = clamp32(longint'(it.py) - cy);
        dz = clamp32(longint'(it.pz) - cz);
        cordic_sincos(it.yaw, s1, c1);
        cordic_sincos(it.pitch, s2, c2);
        nx = mac_q30(dx, c1, dz, s1);
        nz = mac_q30(-dx, s1, dz, c1);
        my = mac_q30(dy, c2, -nz, s2);
        mz = mac_q30(dy, s2, nz, c2);
        r.x = 32'(clamp32(nx + cx));
        r.y = 32'(clamp32(my + cy));
        r.z = 32'(clamp32(mz + cz));
        return r;
    endfunction

    // driver: one nonblocking write per signal per edge
    int send_gap = 0;
    always @(posedge aclk) begin
        logic        nv;
        point_item_t it;
        nv = s_valid;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                it.px = s_point_x;  it.py = s_point_y;  it.pz = s_point_z;
                it.yaw = s_yaw_angle;  it.pitch = s_pitch_angle;
                it.cx = s_pivot_x;  it.cy = s_pivot_y;  it.cz = s_pivot_z;
                expected_points.push_back(rotate_about_pivot(it));
                nv = 1'b0;
                send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_points.size() > 0) begin
                    it = pending_points.pop_front();
                    nv = 1'b1;
                    s_point_x <= it.px;  s_point_y <= it.py;  s_point_z <= it.pz;
                    s_yaw_angle <= it.yaw;  s_pitch_angle <= it.pitch;
                    s_pivot_x <= it.cx;  s_pivot_y <= it.cy;  s_pivot_z <= it.cz;
                end
            end
        end
        s_valid <= nv;
    end

    // monitor with random back-pressure
    int take_stall = 0;
    always @(posedge aclk) begin
        logic     nr;
        rotated_t e;
        nr = m_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h %h %h",
                                 m_rotated_x, m_rotated_y, m_rotated_z);
                end else begin
                    e = expected_points.pop_front();
                    if (e.x !== m_rotated_x || e.y !== m_rotated_y || e.z !== m_rotated_z) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %h %h got %h %h %h",
                                     e.x, e.y, e.z, m_rotated_x, m_rotated_y, m_rotated_z);
                    end
                end
                take_stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
                nr = (take_stall == 0);
            end else if (take_stall > 0) begin
                take_stall--;
                nr = (take_stall == 0);
            end else begin
                nr = 1'b1;
            end
        end
        m_ready <= nr;
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return signed'($urandom());
            1: return signed'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            2: return signed'($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            default: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF - $urandom_range(0, 15)
                                                   : 32'sh8000_0000 + $urandom_range(0, 15);
        endcase
    endfunction

    task automatic queue_point(input logic signed [31:0] px, py, pz,
                               input logic [15:0] yaw, pitch,
                               input logic signed [31:0] cx, cy, cz);
        point_item_t it;
        it.px = px;  it.py = py;  it.pz = pz;
        it.yaw = yaw;  it.pitch = pitch;
        it.cx = cx;  it.cy = cy;  it.cz = cz;
        pending_points.push_back(it);
    endtask

    initial begin
        localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        logic [15:0] angles[10];
        angles = '{16'h0000, 16'h4000, 16'h4001, 16'h8000, 16'hC000,
                   16'hBFFF, 16'hFFFF, 16'h3FFF, 16'h2000, 16'h0001};
        // angles at and around quadrant boundaries
        foreach (angles[i])
            queue_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                        angles[i], angles[(i + 3) % 10], 32'sh0, 32'sh0, 32'sh0);
        // saturation of the difference, of the rotation and of the pivot add-back
        queue_point(MAXV, MAXV, MAXV, 16'h0000, 16'h0000, MINV, MINV, MINV);
        queue_point(MINV, MINV, MINV, 16'h0000, 16'h0000, MAXV, MAXV, MAXV);
        queue_point(MAXV, MAXV, MAXV, 16'h2000, 16'h2000, 32'sh0, 32'sh0, 32'sh0);
        queue_point(MINV, MINV, MINV, 16'hE000, 16'h6000, 32'sh0, 32'sh0, 32'sh0);
        queue_point(MAXV, MINV, MAXV, 16'h8000, 16'h8000, MAXV, MAXV, MAXV);
        queue_point(MINV, MAXV, MINV, 16'hA000, 16'h2000, MINV, MINV, MINV);
        queue_point(32'sh0, 32'sh0, 32'sh0, 16'hFFFF, 16'hFFFF, MAXV, MINV, MAXV);
        queue_point(32'sh1234_5678, 32'shEDCB_A988, 32'sh0000_8000,
                    16'h5555, 16'hAAAA, 32'sh0000_8000, 32'sh0, 32'shFFFF_8000);
        for (int n = 0; n < 450; n++)
            queue_point(rand_coord(), rand_coord(), rand_coord(),
                        16'($urandom()), 16'($urandom()),
                        rand_coord(), rand_coord(), rand_coord());
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_points.size() == 0 && !s_valid);
        wait (expected_points.size() == 0);
        repeat (PIPE_LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/rpc_pkg.sv
sv/rpc_cordic_cell.sv
sv/rpc_rotate_back.sv
sv/rotate_point_about_center_core.sv
sim/rotate_point_about_center_core_tb.sv
